// ===== sv/i2c_target_bus_decoder_defines.svh =====
// ------------------------------------------------------------------------
// i2c target bus decoder assertion macros
// shared concurrent assertion forms for the decoder checker
// ------------------------------------------------------------------------
`ifndef I2C_TARGET_BUS_DECODER_DEFINES_SVH
`define I2C_TARGET_BUS_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c target bus decoder assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c target bus decoder assertion failed");

`endif

// ===== sv/i2ctbd_pkg.sv =====
// ------------------------------------------------------------------------
// i2c target bus decoder package
// transaction payload types, event codes and register indexes
// ------------------------------------------------------------------------
package i2ctbd_pkg;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_START  = 3'd1,
        EV_SELECT = 3'd2,
        EV_READ   = 3'd3,
        EV_WRITE  = 3'd4,
        EV_STOP   = 3'd5,
        EV_NACK   = 3'd6
    } t_event;

    localparam int SLOT_REGS = 4;

    typedef enum logic [2:0] {
        REG_DEV_ADDR_0 = 3'd0,
        REG_DEV_ADDR_1 = 3'd1,
        REG_DEV_ADDR_2 = 3'd2,
        REG_DEV_ADDR_3 = 3'd3,
        REG_DEV_ENABLE = 3'd4
    } t_reg_index;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] read_byte;
    } t_in_item;

    typedef struct packed {
        t_event     event_res;
        logic [1:0] dev_index;
        logic       dev_valid;
        logic       rw_bit;
        logic [7:0] data_byte;
        logic       sda_drive;
        logic       sda_value;
        logic       sda_release;
    } t_out_item;

endpackage

// ===== sv/i2c_target_bus_decoder.sv =====
// ------------------------------------------------------------------------
// i2c target bus decoder
// bit-level i2c target: start/stop detect, address match, byte shifting
// ------------------------------------------------------------------------
// One SCL/SDA sample is taken per input transaction; a new sample can be
// taken on every clock cycle unless a stalled result blocks it. Each sample
// produces exactly one result transaction, held in an output register from
// the cycle after acceptance; the input side stays ready whenever that
// register is empty or is being taken in the same cycle, so with the output
// side always ready the block runs at one sample per cycle, a figure set by
// the single combinational state-update pass (edge detect, shift, address
// compare) between the bus state and result registers. Device slots are at
// APB byte address 4*index; the user must write them only while no
// transaction is in flight, unenforced by the block; pready is tied high.
// ------------------------------------------------------------------------
module i2c_target_bus_decoder #(
    parameter int NUM_DEVICES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2ctbd_pkg::t_in_item  i_in_data,
    // result output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2ctbd_pkg::t_out_item o_out_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import i2ctbd_pkg::*;

    // only the first four slots have address registers
    localparam int SLOTS_USED = (NUM_DEVICES < SLOT_REGS) ? NUM_DEVICES : SLOT_REGS;

    // configuration registers
    logic [7:0] r_dev_addr [SLOT_REGS];
    logic [3:0] r_dev_enable;

    // bus state
    logic       r_prev_scl, r_prev_sda, r_bus_active;
    logic       r_ack_pending, r_await_ack, r_in_data_phase;
    logic [3:0] r_bit_count;
    logic [7:0] r_addr_shift, r_data_shift;
    logic [1:0] r_sel_index;
    logic       r_sel_valid;

    logic       n_prev_sda, n_bus_active;
    logic       n_ack_pending, n_await_ack, n_in_data_phase;
    logic [3:0] n_bit_count;
    logic [7:0] n_addr_shift, n_data_shift;
    logic [1:0] n_sel_index;
    logic       n_sel_valid;

    // result register
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;

    logic       in_accept;
    logic       cfg_write;
    t_reg_index cfg_index;

    // address match on the completed address byte
    logic [7:0] addr_next;
    logic       m_valid;
    logic [1:0] m_index;

    // read bit source: fresh byte at bit 0, shift register after
    logic [7:0] rd_src;
    logic [3:0] bc_inc;
    logic       scl, sda;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------------------------------------------------------
    // apb register file, low address bits ignored
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = t_reg_index'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_DEV_ADDR_0: prdata = {24'd0, r_dev_addr[0]};
            REG_DEV_ADDR_1: prdata = {24'd0, r_dev_addr[1]};
            REG_DEV_ADDR_2: prdata = {24'd0, r_dev_addr[2]};
            REG_DEV_ADDR_3: prdata = {24'd0, r_dev_addr[3]};
            REG_DEV_ENABLE: prdata = {28'd0, r_dev_enable};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // address compare, lowest enabled slot wins
    // ---------------------------------------------------------------
    assign scl       = i_in_data.scl_level;
    assign sda       = i_in_data.sda_level;
    assign addr_next = {r_addr_shift[6:0], sda};
    assign bc_inc    = r_bit_count + 4'd1;

    always_comb begin
        m_valid = 1'b0;
        m_index = '0;
        for (int i = SLOTS_USED - 1; i >= 0; i--) begin
            if (r_dev_enable[i] && (r_dev_addr[i][7:1] == addr_next[7:1])) begin
                m_valid = 1'b1;
                m_index = 2'(i);
            end
        end
    end

    always_comb begin
        if (r_bit_count == 4'd0) begin
            rd_src = r_sel_valid ? i_in_data.read_byte : 8'd0;
        end else begin
            rd_src = r_data_shift;
        end
    end

    // ---------------------------------------------------------------
    // one pass of the bus state machine per sample
    // ---------------------------------------------------------------
    always_comb begin
        n_prev_sda      = sda;
        n_bus_active    = r_bus_active;
        n_ack_pending   = r_ack_pending;
        n_await_ack     = r_await_ack;
        n_in_data_phase = r_in_data_phase;
        n_bit_count     = r_bit_count;
        n_addr_shift    = r_addr_shift;
        n_data_shift    = r_data_shift;
        n_sel_index     = r_sel_index;
        n_sel_valid     = r_sel_valid;
        n_out_data      = '0;
        n_out_data.event_res = EV_NONE;

        if (r_prev_scl && scl && r_prev_sda && !sda) begin
            // start condition resets the whole transfer
            n_out_data.event_res = EV_START;
            n_bus_active    = 1'b1;
            n_ack_pending   = 1'b0;
            n_await_ack     = 1'b0;
            n_in_data_phase = 1'b0;
            n_bit_count     = '0;
            n_addr_shift    = '0;
            n_data_shift    = '0;
            n_sel_valid     = 1'b0;
            n_sel_index     = '0;
        end else if (r_prev_scl && scl && !r_prev_sda && sda) begin
            // stop condition, selection kept
            n_out_data.event_res = EV_STOP;
            n_bus_active = 1'b0;
        end else if (r_prev_scl && !scl) begin
            // falling scl: let go of sda for the master's ack
            n_out_data.sda_release = r_await_ack;
        end else if (!r_prev_scl && scl && r_bus_active) begin
            if (r_ack_pending) begin
                n_out_data.sda_drive = 1'b1;
                n_prev_sda    = 1'b0;
                n_ack_pending = 1'b0;
            end else if (r_await_ack) begin
                if (sda) begin
                    n_out_data.event_res = EV_NACK;
                    n_bus_active = 1'b0;
                end
                n_await_ack = 1'b0;
            end else if (!r_in_data_phase) begin
                n_addr_shift = addr_next;
                n_bit_count  = bc_inc;
                if (bc_inc[3]) begin
                    // address byte complete
                    n_out_data.event_res = EV_SELECT;
                    n_sel_valid     = m_valid;
                    n_sel_index     = m_index;
                    n_bit_count     = '0;
                    n_in_data_phase = 1'b1;
                    n_data_shift    = '0;
                    n_ack_pending   = 1'b1;
                end
            end else begin
                if (r_addr_shift[0]) begin
                    // read: drive msb first
                    if (r_bit_count == 4'd0 && r_sel_valid) begin
                        n_out_data.event_res = EV_READ;
                    end
                    n_data_shift = rd_src;
                    n_out_data.sda_drive = 1'b1;
                    n_out_data.sda_value = rd_src[~r_bit_count[2:0]];
                    n_prev_sda = rd_src[~r_bit_count[2:0]];
                end else begin
                    n_data_shift = {r_data_shift[6:0], sda};
                end
                n_bit_count = bc_inc;
                if (bc_inc[3]) begin
                    if (r_addr_shift[0]) begin
                        n_await_ack = 1'b1;
                    end else begin
                        n_ack_pending = 1'b1;
                        n_out_data.event_res = EV_WRITE;
                        n_out_data.data_byte = {r_data_shift[6:0], sda};
                    end
                    n_data_shift = '0;
                    n_bit_count  = '0;
                end
            end
        end

        n_out_data.dev_index = n_sel_index;
        n_out_data.dev_valid = n_sel_valid;
        n_out_data.rw_bit    = n_in_data_phase && n_addr_shift[0];
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_REGS; i++) begin
                r_dev_addr[i] <= '0;
            end
            r_dev_enable    <= '0;
            r_prev_scl      <= 1'b0;
            r_prev_sda      <= 1'b0;
            r_bus_active    <= 1'b0;
            r_ack_pending   <= 1'b0;
            r_await_ack     <= 1'b0;
            r_in_data_phase <= 1'b0;
            r_bit_count     <= '0;
            r_addr_shift    <= '0;
            r_data_shift    <= '0;
            r_sel_index     <= '0;
            r_sel_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_DEV_ADDR_0: r_dev_addr[0] <= pwdata[7:0];
                    REG_DEV_ADDR_1: r_dev_addr[1] <= pwdata[7:0];
                    REG_DEV_ADDR_2: r_dev_addr[2] <= pwdata[7:0];
                    REG_DEV_ADDR_3: r_dev_addr[3] <= pwdata[7:0];
                    REG_DEV_ENABLE: r_dev_enable  <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_prev_scl      <= scl;
                r_prev_sda      <= n_prev_sda;
                r_bus_active    <= n_bus_active;
                r_ack_pending   <= n_ack_pending;
                r_await_ack     <= n_await_ack;
                r_in_data_phase <= n_in_data_phase;
                r_bit_count     <= n_bit_count;
                r_addr_shift    <= n_addr_shift;
                r_data_shift    <= n_data_shift;
                r_sel_index     <= n_sel_index;
                r_sel_valid     <= n_sel_valid;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== sv/i2ctbd_checker.sv =====
// ------------------------------------------------------------------------
// i2c target bus decoder checker
// port-level assertions on handshake and result consistency
// ------------------------------------------------------------------------
`include "i2c_target_bus_decoder_defines.svh"

module i2ctbd_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input i2ctbd_pkg::t_out_item o_out_data
);
    import i2ctbd_pkg::*;

    // a stalled result holds
    `TBD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    // an empty result register never blocks the input
    `TBD_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // every accepted sample gives a result next cycle
    `TBD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)
    // start clears the selection, the direction and the sda drive
    `TBD_ASSERT_NOW(a_start_clears, i_clk, i_rst_n, o_out_valid && (o_out_data.event_res == EV_START), !o_out_data.dev_valid && !o_out_data.rw_bit && !o_out_data.sda_drive)

endmodule

bind i2c_target_bus_decoder i2ctbd_checker u_i2ctbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
